>>> rtl/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants of the 4x4 matrix by vector transform unit.
// ----------------------------------------------------------------------------
package vmt_pkg;

    localparam int VMT_COMPONENT_WIDTH = 32;
    localparam int VMT_FRACTION_BITS   = 16;

    localparam int FIELD_W     = 32;
    localparam int REG_W       = 64;
    localparam int NUM_REGS    = 8;
    localparam int CFG_INDEX_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS01 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS23 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS01 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS23 = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS01 = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS23 = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS01 = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS23 = 8'd7;

    // Reset values of the matrix registers.
    localparam logic [REG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_4000_0000;
    localparam logic [REG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RST_ROW3_COLS01 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW3_COLS23 = 64'h0001_0000_0000_0000;

    // Transform selection.
    localparam logic FUNC_ROW_TIMES_MAT = 1'b0;
    localparam logic FUNC_MAT_TIMES_COL = 1'b1;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] t_mat;

    typedef struct packed {
        logic                      func;
        logic signed [FIELD_W-1:0] in_x;
        logic signed [FIELD_W-1:0] in_y;
        logic signed [FIELD_W-1:0] in_z;
        logic signed [FIELD_W-1:0] in_w;
    } t_vec_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic signed [FIELD_W-1:0] out_w;
        logic                      overflow;
    } t_vec_out;

    // Load enables of the two multiply-accumulate stages.
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_mac_ctl;

endpackage

>>> rtl/vmt_opsel.sv
// ----------------------------------------------------------------------------
// vmt_opsel
// First stage: picks each coefficient for the chosen transform and narrows
// components and coefficients to the working width.
// ----------------------------------------------------------------------------
module vmt_opsel
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = VMT_COMPONENT_WIDTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  t_vec_in                                    i_word,
    input  t_mat                                       i_mat,
    output logic [3:0][COMPONENT_WIDTH-1:0]            o_vec,
    output logic [3:0][3:0][COMPONENT_WIDTH-1:0]       o_coef
);

    localparam int CW = COMPONENT_WIDTH;

    logic [3:0][CW-1:0]      n_vec;
    logic [3:0][3:0][CW-1:0] n_coef;
    logic [3:0][CW-1:0]      r_vec;
    logic [3:0][3:0][CW-1:0] r_coef;

    // Coefficient m[r][c] sits in register 2r + c/2, low or high half by c.
    always_comb begin
        n_vec[0] = i_word.in_x[CW-1:0];
        n_vec[1] = i_word.in_y[CW-1:0];
        n_vec[2] = i_word.in_z[CW-1:0];
        n_vec[3] = i_word.in_w[CW-1:0];
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                if (i_word.func == FUNC_MAT_TIMES_COL) begin
                    n_coef[i][k] = i_mat[2*i + (k >> 1)][32*(k & 1) +: CW];
                end else begin
                    n_coef[i][k] = i_mat[2*k + (i >> 1)][32*(i & 1) +: CW];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec  <= n_vec;
            r_coef <= n_coef;
        end
    end

    assign o_vec  = r_vec;
    assign o_coef = r_coef;

endmodule

>>> rtl/vmt_mac.sv
// ----------------------------------------------------------------------------
// vmt_mac
// Second and third stages: sixteen signed products, then four exact sums of
// four products each.
// ----------------------------------------------------------------------------
module vmt_mac
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = VMT_COMPONENT_WIDTH
) (
    input  logic                                       i_clk,
    input  t_mac_ctl                                   i_ctl,
    input  logic [3:0][COMPONENT_WIDTH-1:0]            i_vec,
    input  logic [3:0][3:0][COMPONENT_WIDTH-1:0]       i_coef,
    output logic [3:0][2*COMPONENT_WIDTH+1:0]          o_sum
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int PW = 2 * CW;
    localparam int SW = 2 * CW + 2;

    logic [3:0][3:0][PW-1:0] n_prod;
    logic [3:0][3:0][PW-1:0] r_prod;
    logic [3:0][SW-1:0]      n_sum;
    logic [3:0][SW-1:0]      r_sum;

    // Both operands are sign-extended to the product width before the multiply.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                n_prod[i][k] = PW'($signed(i_vec[k])) * PW'($signed(i_coef[i][k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= n_prod;
        end
    end

    // Two guard bits keep the four-product sum exact.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_sum[i] = SW'($signed(r_prod[i][0])) + SW'($signed(r_prod[i][1]))
                     + SW'($signed(r_prod[i][2])) + SW'($signed(r_prod[i][3]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> rtl/vmt_sat.sv
// ----------------------------------------------------------------------------
// vmt_sat
// Last stage: drops the fraction bits with an arithmetic shift, saturates each
// component and holds the finished output word.
// ----------------------------------------------------------------------------
module vmt_sat
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = VMT_COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = VMT_FRACTION_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [3:0][2*COMPONENT_WIDTH+1:0]          i_sum,
    output t_vec_out                                   o_word
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int SW = 2 * CW + 2;

    localparam logic signed [SW-1:0] SAT_MAX = (SW'(1) << (CW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [SW-1:0]     shifted [4];
    logic [3:0][FIELD_W-1:0]  res;
    logic [3:0]               sat;
    t_vec_out                 n_word;
    t_vec_out                 r_word;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            shifted[i] = $signed(i_sum[i]) >>> FRACTION_BITS;
            if (shifted[i] > SAT_MAX) begin
                res[i] = FIELD_W'($signed(SAT_MAX[CW-1:0]));
                sat[i] = 1'b1;
            end else if (shifted[i] < SAT_MIN) begin
                res[i] = FIELD_W'($signed(SAT_MIN[CW-1:0]));
                sat[i] = 1'b1;
            end else begin
                res[i] = FIELD_W'($signed(shifted[i][CW-1:0]));
                sat[i] = 1'b0;
            end
        end
        n_word.out_x    = res[0];
        n_word.out_y    = res[1];
        n_word.out_z    = res[2];
        n_word.out_w    = res[3];
        n_word.overflow = |sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> rtl/vec4_matrix_transform_unit.sv
// ----------------------------------------------------------------------------
// vec4_matrix_transform_unit
// Transforms a stream of Q16.16 four-component vectors by a 4x4 matrix.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid, o_in_stall, i_in_word) takes one vector word
// per cycle while o_in_stall is low; func selects row vector times matrix or
// matrix times column vector. The output channel (o_out_valid, i_out_stall,
// o_out_word) returns one word per input word, in order, with the overflow
// flag set when any component saturated.
// The matrix lives in eight 64-bit registers written through the cfg channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data); o_cfg_ready is always
// high and writes to an index past the last register are dropped. Write the
// matrix only while no word is in flight.
// Four registered stages: operand select, multiply, four-term sum, shift
// and saturate. Throughput is one word per cycle while i_out_stall is low.
// When the receiver stalls, the stall ripples back only through full
// stages, so bubbles are squeezed out before o_in_stall rises.
// Reset clears all stage valid bits and loads the default matrix.
// ----------------------------------------------------------------------------
module vec4_matrix_transform_unit
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = VMT_COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = VMT_FRACTION_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_vec_in                 i_in_word,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_vec_out                o_out_word,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [REG_W-1:0]        i_cfg_data
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int SW = 2 * CW + 2;

    t_mat                    r_mat;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic                    r_v4;
    logic                    en1;
    logic                    en2;
    logic                    en3;
    logic                    en4;
    t_mac_ctl                mac_ctl;
    logic [3:0][CW-1:0]      vec;
    logic [3:0][3:0][CW-1:0] coef;
    logic [3:0][SW-1:0]      sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[REG_ROW0_COLS01[2:0]] <= RST_ROW0_COLS01;
            r_mat[REG_ROW0_COLS23[2:0]] <= RST_ROW0_COLS23;
            r_mat[REG_ROW1_COLS01[2:0]] <= RST_ROW1_COLS01;
            r_mat[REG_ROW1_COLS23[2:0]] <= RST_ROW1_COLS23;
            r_mat[REG_ROW2_COLS01[2:0]] <= RST_ROW2_COLS01;
            r_mat[REG_ROW2_COLS23[2:0]] <= RST_ROW2_COLS23;
            r_mat[REG_ROW3_COLS01[2:0]] <= RST_ROW3_COLS01;
            r_mat[REG_ROW3_COLS23[2:0]] <= RST_ROW3_COLS23;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROW0_COLS01: r_mat[REG_ROW0_COLS01[2:0]] <= i_cfg_data;
                REG_ROW0_COLS23: r_mat[REG_ROW0_COLS23[2:0]] <= i_cfg_data;
                REG_ROW1_COLS01: r_mat[REG_ROW1_COLS01[2:0]] <= i_cfg_data;
                REG_ROW1_COLS23: r_mat[REG_ROW1_COLS23[2:0]] <= i_cfg_data;
                REG_ROW2_COLS01: r_mat[REG_ROW2_COLS01[2:0]] <= i_cfg_data;
                REG_ROW2_COLS23: r_mat[REG_ROW2_COLS23[2:0]] <= i_cfg_data;
                REG_ROW3_COLS01: r_mat[REG_ROW3_COLS01[2:0]] <= i_cfg_data;
                REG_ROW3_COLS23: r_mat[REG_ROW3_COLS23[2:0]] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    assign en4 = !r_v4 || !i_out_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign mac_ctl.en_mul = en2;
    assign mac_ctl.en_sum = en3;

    vmt_opsel #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_opsel (
        .i_clk  (i_clk),
        .i_en   (en1),
        .i_word (i_in_word),
        .i_mat  (r_mat),
        .o_vec  (vec),
        .o_coef (coef)
    );

    vmt_mac #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_vec  (vec),
        .i_coef (coef),
        .o_sum  (sum)
    );

    vmt_sat #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_sat (
        .i_clk  (i_clk),
        .i_en   (en4),
        .i_sum  (sum),
        .o_word (o_out_word)
    );

    assign o_out_valid = r_v4;

`ifndef SYNTHESIS
    localparam logic [FIELD_W-1:0] OUT_MAX =
        FIELD_W'((64'(1) << (COMPONENT_WIDTH - 1)) - 64'(1));
    localparam logic [FIELD_W-1:0] OUT_MIN = ~OUT_MAX;

    // Reset empties every stage.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3 && !r_v4)
        else $error("pipeline not empty after reset");

    // With the output side open, a word in the sum stage reaches the output.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_out_stall |=> r_v4)
        else $error("word in sum stage did not advance");

    // Input is held off only when all stages are full and the output stalls.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // The overflow flag implies at least one component sits at a limit.
    a_overflow_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.overflow |->
            o_out_word.out_x == OUT_MAX || o_out_word.out_x == OUT_MIN ||
            o_out_word.out_y == OUT_MAX || o_out_word.out_y == OUT_MIN ||
            o_out_word.out_z == OUT_MAX || o_out_word.out_z == OUT_MIN ||
            o_out_word.out_w == OUT_MAX || o_out_word.out_w == OUT_MIN)
        else $error("overflow flagged without a saturated component");
`endif

endmodule

>>> tb/vec4_matrix_transform_unit_tb.sv
// ----------------------------------------------------------------------------
// vec4_matrix_transform_unit_tb
// The testbench loads matrices through the cfg channel and streams vector
// words through the unit. Each accepted word is transformed by a local copy
// of the matrix, and every output word is checked in order against it.
// Random idle cycles, a long receiver hold-off and a sender pause stress
// the two handshakes.
// ----------------------------------------------------------------------------
module vec4_matrix_transform_unit_tb;
    import vmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int            CW            = VMT_COMPONENT_WIDTH;
    localparam int            FB            = VMT_FRACTION_BITS;
    localparam int            IDLE_PCT      = 6;
    localparam int            HOLD_CYCLES   = 80;
    localparam int            DRAIN_CYCLES  = 8;
    localparam int            WATCHDOG_MAX  = 2000;
    localparam int            REPORT_MAX    = 10;
    localparam int            RANDOM_PHASES = 7;
    localparam int            PHASE_ITEMS   = 120;
    localparam logic [31:0]   Q_ONE         = 32'h0001_0000;
    localparam logic [31:0]   Q_HALF        = 32'h0000_8000;
    localparam logic [31:0]   Q_TWO         = 32'h0002_0000;
    localparam logic [31:0]   Q_MINUS_ONE   = 32'hFFFF_0000;
    localparam logic [31:0]   S32_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0]   S32_MIN       = 32'h8000_0000;
    localparam logic [31:0]   ALL_ONES      = 32'hFFFF_FFFF;

    // Styles of random matrix coefficients.
    localparam int COEF_FULL    = 0;
    localparam int COEF_SMALL   = 1;
    localparam int COEF_EXTREME = 2;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_vec_in                i_in_word;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_vec_out               o_out_word;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]       i_cfg_data;

    t_mat     matrix_regs;
    t_vec_out expected_vectors[$];
    t_vec_out expected_word;
    int       failures     = 0;
    int       idle_cycles  = 0;
    bit       quiet_mode   = 1'b0;
    bit       hold_request = 1'b0;
    int       hold_left    = 0;

    vec4_matrix_transform_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Transform predictor
    // ------------------------------------------------------------------------

    // Takes the low CW bits of a 32-bit slot and sign-extends them.
    function automatic logic signed [67:0] widen_component(input logic [31:0] raw);
        logic signed [31:0] narrowed;
        narrowed = signed'(raw << (32 - CW)) >>> (32 - CW);
        return narrowed;
    endfunction

    function automatic logic signed [67:0] coefficient(input int row, input int col);
        logic [REG_W-1:0] reg_word;
        reg_word = matrix_regs[row * 2 + col / 2];
        return widen_component((col % 2 == 1) ? reg_word[63:32] : reg_word[31:0]);
    endfunction

    function automatic t_vec_out transform_vector(input t_vec_in word);
        logic signed [67:0] comp [4];
        logic signed [67:0] acc;
        logic signed [67:0] shifted;
        logic signed [67:0] max_val;
        logic signed [67:0] min_val;
        logic        [31:0] res [4];
        logic               ovf;
        t_vec_out           out_word;
        comp[0] = widen_component(word.in_x);
        comp[1] = widen_component(word.in_y);
        comp[2] = widen_component(word.in_z);
        comp[3] = widen_component(word.in_w);
        max_val = (68'sd1 <<< (CW - 1)) - 68'sd1;
        min_val = -(68'sd1 <<< (CW - 1));
        ovf     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            acc = '0;
            // The 68-bit accumulator holds the four-product sum exactly.
            for (int k = 0; k < 4; k++) begin
                if (word.func == FUNC_MAT_TIMES_COL) begin
                    acc = acc + comp[k] * coefficient(i, k);
                end else begin
                    acc = acc + comp[k] * coefficient(k, i);
                end
            end
            shifted = acc >>> FB;
            if (shifted > max_val) begin
                res[i] = max_val[31:0];
                ovf    = 1'b1;
            end else if (shifted < min_val) begin
                res[i] = min_val[31:0];
                ovf    = 1'b1;
            end else begin
                res[i] = shifted[31:0];
            end
        end
        out_word.out_x    = res[0];
        out_word.out_y    = res[1];
        out_word.out_z    = res[2];
        out_word.out_w    = res[3];
        out_word.overflow = ovf;
        return out_word;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_vec_in make_vector(input logic func, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z,
                                            input logic [31:0] w);
        t_vec_in word;
        word.func = func;
        word.in_x = x;
        word.in_y = y;
        word.in_z = z;
        word.in_w = w;
        return word;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(5))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3:       return ALL_ONES;
            4:       return 32'd1;
            default: return Q_ONE;
        endcase
    endfunction

    // Equal shares of full-range and small values, the rest extremes; the small ones keep sums in range.
    function automatic logic [31:0] random_component();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            return $urandom;
        end else if (pick < 8) begin
            return 32'(int'($urandom_range(0, 2097151)) - 1048576);
        end
        return pick_extreme();
    endfunction

    function automatic logic [31:0] random_coefficient(input int style);
        case (style)
            COEF_SMALL:   return 32'(int'($urandom_range(0, 524287)) - 262144);
            COEF_EXTREME: return pick_extreme();
            default:      return $urandom;
        endcase
    endfunction

    function automatic t_mat random_matrix(input int style);
        t_mat m;
        for (int i = 0; i < NUM_REGS; i++) begin
            m[i] = {random_coefficient(style), random_coefficient(style)};
        end
        return m;
    endfunction

    function automatic t_mat fill_matrix(input logic [31:0] hi_coef, input logic [31:0] lo_coef);
        t_mat m;
        for (int i = 0; i < NUM_REGS; i++) begin
            m[i] = {hi_coef, lo_coef};
        end
        return m;
    endfunction

    function automatic t_vec_in random_vector();
        return make_vector(1'($urandom_range(1)), random_component(), random_component(),
                           random_component(), random_component());
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------

    task automatic send_vector(input t_vec_in word);
        @(negedge i_clk);
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = word;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_vectors.push_back(transform_vector(word));
    endtask

    task automatic send_both_funcs(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [31:0] w);
        send_vector(make_vector(FUNC_ROW_TIMES_MAT, x, y, z, w));
        send_vector(make_vector(FUNC_MAT_TIMES_COL, x, y, z, w));
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_vector(random_vector());
        end
    endtask

    // Lowers valid, waits for every expected word, then lets the pipe settle.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_vectors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_matrix_reg(input logic [CFG_INDEX_W-1:0] index,
                                    input logic [REG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (index < NUM_REGS) begin
            matrix_regs[index] = data;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_matrix(input t_mat m);
        for (int i = 0; i < NUM_REGS; i++) begin
            write_matrix_reg(CFG_INDEX_W'(i), m[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The reset matrix scales x by 16384 and passes y, z and w through.
    task automatic test_reset_matrix();
        send_both_funcs(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        send_both_funcs(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        send_both_funcs(Q_ONE, Q_MINUS_ONE, Q_HALF, Q_TWO);
        send_both_funcs(32'd1, '0, ALL_ONES, Q_ONE);
        wait_drained();
    endtask

    task automatic test_ignored_index();
        write_matrix_reg(CFG_INDEX_W'(NUM_REGS), {$urandom, $urandom});
        write_matrix_reg('1, {$urandom, $urandom});
        send_both_funcs(Q_ONE, Q_TWO, Q_MINUS_ONE, Q_HALF);
        wait_drained();
    endtask

    // Products of extreme coefficients drive the sum past 64 bits.
    task automatic test_extreme_matrix();
        load_matrix(fill_matrix(S32_MIN, S32_MIN));
        send_both_funcs(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        send_both_funcs(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        wait_drained();
        load_matrix(fill_matrix(S32_MAX, S32_MAX));
        send_both_funcs(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        send_both_funcs(S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        wait_drained();
        load_matrix(fill_matrix(ALL_ONES, ALL_ONES));
        send_both_funcs(S32_MIN, ALL_ONES, 32'd1, S32_MAX);
        wait_drained();
        load_matrix(fill_matrix(S32_MAX, S32_MIN));
        send_both_funcs(S32_MIN, S32_MIN, S32_MAX, S32_MAX);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_matrix(random_matrix(phase % 3));
            send_random(PHASE_ITEMS);
            wait_drained();
        end
    endtask

    // The receiver holds off long enough for the pipe to fill and stall the input.
    task automatic test_output_backpressure();
        load_matrix(random_matrix(COEF_SMALL));
        hold_request = 1'b1;
        send_random(40);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        load_matrix(random_matrix(COEF_FULL));
        send_random(20);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_vectors.size() != 0) begin
            @(posedge i_clk);
        end
        send_random(20);
        wait_drained();
    endtask

    task automatic test_quiet_stream();
        load_matrix(random_matrix(COEF_SMALL));
        quiet_mode = 1'b1;
        send_random(60);
        wait_drained();
        quiet_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left   = hold_left - 1;
            end else if (quiet_mode) begin
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_vectors.size() == 0) begin
                failures = failures + 1;
                if (failures <= REPORT_MAX) begin
                    $display("unexpected output word %h at %0t", o_out_word, $realtime);
                end
            end else begin
                expected_word = expected_vectors.pop_front();
                if (o_out_word.out_x !== expected_word.out_x
                        || o_out_word.out_y !== expected_word.out_y
                        || o_out_word.out_z !== expected_word.out_z
                        || o_out_word.out_w !== expected_word.out_w
                        || o_out_word.overflow !== expected_word.overflow) begin
                    failures = failures + 1;
                    if (failures <= REPORT_MAX) begin
                        $display("mismatch at %0t: expected %h %h %h %h ovf %b, got %h %h %h %h ovf %b",
                                 $realtime, expected_word.out_x, expected_word.out_y,
                                 expected_word.out_z, expected_word.out_w,
                                 expected_word.overflow, o_out_word.out_x, o_out_word.out_y,
                                 o_out_word.out_z, o_out_word.out_w, o_out_word.overflow);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        matrix_regs[REG_ROW0_COLS01] = RST_ROW0_COLS01;
        matrix_regs[REG_ROW0_COLS23] = RST_ROW0_COLS23;
        matrix_regs[REG_ROW1_COLS01] = RST_ROW1_COLS01;
        matrix_regs[REG_ROW1_COLS23] = RST_ROW1_COLS23;
        matrix_regs[REG_ROW2_COLS01] = RST_ROW2_COLS01;
        matrix_regs[REG_ROW2_COLS23] = RST_ROW2_COLS23;
        matrix_regs[REG_ROW3_COLS01] = RST_ROW3_COLS01;
        matrix_regs[REG_ROW3_COLS23] = RST_ROW3_COLS23;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_matrix();
        test_ignored_index();
        test_extreme_matrix();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        test_quiet_stream();

        if (failures == 0 && expected_vectors.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
